[sv/kfli_pkg.sv]
// shared constants, types and command/status bundles of the keyframe interpolator
`default_nettype none

package kfli_pkg;

    // key table geometry
    localparam int MAX_KEYS = 64;
    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int KC_W     = 7;

    // field widths
    localparam int TIME_W   = 24;
    localparam int VAL_W    = 32;
    localparam int FRAC_W   = 16;
    localparam int NUM_COMP = 3;
    localparam int COMP_W   = $clog2(NUM_COMP);
    localparam int ENTRY_W  = TIME_W + NUM_COMP * VAL_W;

    // interpolation arithmetic
    localparam int MAG_W      = VAL_W + 1;
    localparam int HI_W       = MAG_W - FRAC_W;
    localparam int DIV_STEPS  = FRAC_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // item operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        PICK_START,
        PICK_END,
        PICK_LERP
    } pick_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_FILL,
        ST_SCAN,
        ST_FETCH_WAIT,
        ST_FETCH_START,
        ST_FETCH_END,
        ST_CLASSIFY,
        ST_DIVIDE,
        ST_DIFF,
        ST_MUL,
        ST_ACC,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic              load_key;
        logic              start_query;
        logic              ptr_inc;
        logic              scan_step;
        logic              scan_done;
        logic              latch_start;
        logic              latch_end;
        logic              classify;
        logic              div_step;
        logic              diff;
        logic              mul;
        logic              acc;
        logic              load_out;
        logic [COMP_W-1:0] comp;
    } cmd_t;

    typedef struct packed {
        logic single;
        logic hit;
        logic scan_last;
        logic need_div;
    } status_t;

endpackage

`default_nettype wire

[sv/kfli_datapath.sv]
// key table, segment search, divider and interpolation datapath
`default_nettype none

module kfli_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire kfli_pkg::cmd_t                    cmd,
    output kfli_pkg::status_t                      status,
    input  wire logic                              cfg_we,
    input  wire logic [kfli_pkg::KC_W-1:0]         cfg_data,
    input  wire logic [kfli_pkg::IDX_W-1:0]        key_index,
    input  wire logic [kfli_pkg::TIME_W-1:0]       key_time,
    input  wire logic signed [kfli_pkg::VAL_W-1:0] key_x,
    input  wire logic signed [kfli_pkg::VAL_W-1:0] key_y,
    input  wire logic signed [kfli_pkg::VAL_W-1:0] key_z,
    input  wire logic [kfli_pkg::TIME_W-1:0]       query_time,
    output logic signed [kfli_pkg::VAL_W-1:0]      out_x,
    output logic signed [kfli_pkg::VAL_W-1:0]      out_y,
    output logic signed [kfli_pkg::VAL_W-1:0]      out_z,
    output logic [kfli_pkg::IDX_W-1:0]             segment,
    output logic                                   factor_clamped,
    output logic                                   empty_segment
);

    localparam int TW  = kfli_pkg::TIME_W;
    localparam int VW  = kfli_pkg::VAL_W;
    localparam int FW  = kfli_pkg::FRAC_W;
    localparam int MW  = kfli_pkg::MAG_W;
    localparam int HW  = kfli_pkg::HI_W;
    localparam int IW  = kfli_pkg::IDX_W;
    localparam int KW  = kfli_pkg::KC_W;
    localparam int EW  = kfli_pkg::ENTRY_W;
    localparam int NC  = kfli_pkg::NUM_COMP;

    logic [EW-1:0] key_mem [kfli_pkg::MAX_KEYS];
    logic [EW-1:0] rd_data_reg;

    logic [KW-1:0] kc_reg;
    logic [KW-1:0] kc_eff;

    logic [IW-1:0] ptr_reg;
    logic [IW-1:0] cand_reg;
    logic [IW-1:0] seg_reg;
    logic [TW-1:0] q_reg;
    logic [TW-1:0] t1_reg;
    logic [TW-1:0] t2_reg;
    logic [VW-1:0] s_reg [NC];
    logic [VW-1:0] e_reg [NC];
    logic [VW-1:0] r_reg [NC];

    kfli_pkg::pick_t pick_reg;
    logic            clamp_reg;
    logic            empty_reg;

    logic [TW-1:0] ad_reg;
    logic [TW-1:0] rem_reg;
    logic [FW-1:0] f_reg;

    logic          neg_reg;
    logic [MW-1:0] m_reg;
    logic [FW+HW-1:0] ph_reg;
    logic [2*FW-1:0]  pl_reg;

    logic [VW-1:0] out_x_reg;
    logic [VW-1:0] out_y_reg;
    logic [VW-1:0] out_z_reg;
    logic [IW-1:0] out_seg_reg;
    logic          out_clamp_reg;
    logic          out_empty_reg;

    logic [TW-1:0] rd_time;
    logic [VW-1:0] rd_val [NC];

    logic [TW:0]   den;
    logic [TW:0]   num;
    logic          den_neg;
    logic          num_neg;
    logic [TW:0]   ad_full;
    logic [TW:0]   an_full;
    logic          den_zero;
    logic          num_zero;
    logic          end_over;
    logic          end_equal;

    logic [TW:0]   rem2;
    logic [TW:0]   rem_sub;

    logic [VW-1:0] s_sel;
    logic [VW-1:0] e_sel;
    logic [MW-1:0] d_diff;
    logic [FW+HW-1:0] ph_next;
    logic [2*FW-1:0]  pl_next;
    logic [FW+HW-1:0] q_sum;

    // table entry layout: time, x, y, z
    assign rd_time   = rd_data_reg[EW-1 -: TW];
    assign rd_val[0] = rd_data_reg[3*VW-1 -: VW];
    assign rd_val[1] = rd_data_reg[2*VW-1 -: VW];
    assign rd_val[2] = rd_data_reg[VW-1 -: VW];

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_mem[key_index] <= {key_time, key_x, key_y, key_z};
        end
        rd_data_reg <= key_mem[ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kc_reg <= KW'(1);
        end
        else if (cfg_we)
        begin
            kc_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (kc_reg == '0)
        begin
            kc_eff = KW'(1);
        end
        else if (kc_reg > KW'(kfli_pkg::MAX_KEYS))
        begin
            kc_eff = KW'(kfli_pkg::MAX_KEYS);
        end
        else
        begin
            kc_eff = kc_reg;
        end
    end

    // segment classification
    assign den      = {1'b0, t2_reg} - {1'b0, t1_reg};
    assign num      = {1'b0, q_reg} - {1'b0, t1_reg};
    assign den_neg  = den[TW];
    assign num_neg  = num[TW];
    assign ad_full  = den_neg ? -den : den;
    assign an_full  = num_neg ? -num : num;
    assign den_zero = (t2_reg == t1_reg);
    assign num_zero = (q_reg == t1_reg);
    // same-sign case: factor above one iff query lies past the end key
    assign end_over  = den_neg ? (q_reg < t2_reg) : (q_reg > t2_reg);
    assign end_equal = (q_reg == t2_reg);

    assign status.single    = (kc_eff == KW'(1));
    assign status.hit       = (q_reg < rd_time);
    assign status.scan_last = ((KW'(cand_reg) + KW'(2)) == kc_eff);
    assign status.need_div  = !den_zero && !num_zero && (num_neg == den_neg)
                              && !end_over && !end_equal;

    // restoring divider step, remainder always below divisor
    assign rem2    = {rem_reg, 1'b0};
    assign rem_sub = rem2 - {1'b0, ad_reg};

    // per-component lerp
    assign s_sel   = s_reg[cmd.comp];
    assign e_sel   = e_reg[cmd.comp];
    assign d_diff  = {e_sel[VW-1], e_sel} - {s_sel[VW-1], s_sel};
    assign ph_next = {{HW{1'b0}}, f_reg} * {{FW{1'b0}}, m_reg[MW-1:FW]};
    assign pl_next = {{FW{1'b0}}, f_reg} * {{FW{1'b0}}, m_reg[FW-1:0]};
    assign q_sum   = ph_reg + (FW+HW)'(pl_reg[2*FW-1:FW]);

    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            q_reg     <= query_time;
            cand_reg  <= '0;
            seg_reg   <= '0;
            ptr_reg   <= status.single ? IW'(0) : IW'(1);
            pick_reg  <= kfli_pkg::PICK_START;
            clamp_reg <= 1'b0;
            empty_reg <= 1'b0;
        end
        if (cmd.ptr_inc)
        begin
            ptr_reg <= ptr_reg + IW'(1);
        end
        if (cmd.scan_step)
        begin
            cand_reg <= cand_reg + IW'(1);
            ptr_reg  <= ptr_reg + IW'(1);
        end
        if (cmd.scan_done)
        begin
            seg_reg <= status.hit ? cand_reg : IW'(0);
            ptr_reg <= status.hit ? cand_reg : IW'(0);
        end
        if (cmd.latch_start)
        begin
            t1_reg <= rd_time;
            for (int i = 0; i < NC; i++)
            begin
                s_reg[i] <= rd_val[i];
            end
        end
        if (cmd.latch_end)
        begin
            t2_reg <= rd_time;
            for (int i = 0; i < NC; i++)
            begin
                e_reg[i] <= rd_val[i];
            end
        end
        if (cmd.classify)
        begin
            ad_reg  <= ad_full[TW-1:0];
            rem_reg <= an_full[TW-1:0];
            f_reg   <= '0;
            priority if (den_zero)
            begin
                empty_reg <= 1'b1;
                pick_reg  <= kfli_pkg::PICK_START;
            end
            else if (num_zero)
            begin
                pick_reg <= kfli_pkg::PICK_START;
            end
            else if (num_neg != den_neg)
            begin
                clamp_reg <= 1'b1;
                pick_reg  <= kfli_pkg::PICK_START;
            end
            else if (end_over)
            begin
                clamp_reg <= 1'b1;
                pick_reg  <= kfli_pkg::PICK_END;
            end
            else if (end_equal)
            begin
                pick_reg <= kfli_pkg::PICK_END;
            end
            else
            begin
                pick_reg <= kfli_pkg::PICK_LERP;
            end
        end
        if (cmd.div_step)
        begin
            if (!rem_sub[TW])
            begin
                rem_reg <= rem_sub[TW-1:0];
                f_reg   <= {f_reg[FW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem2[TW-1:0];
                f_reg   <= {f_reg[FW-2:0], 1'b0};
            end
        end
        if (cmd.diff)
        begin
            neg_reg <= d_diff[MW-1];
            m_reg   <= d_diff[MW-1] ? -d_diff : d_diff;
        end
        if (cmd.mul)
        begin
            ph_reg <= ph_next;
            pl_reg <= pl_next;
        end
        if (cmd.acc)
        begin
            r_reg[cmd.comp] <= neg_reg ? (s_sel - q_sum[VW-1:0])
                                       : (s_sel + q_sum[VW-1:0]);
        end
        if (cmd.load_out)
        begin
            out_seg_reg   <= seg_reg;
            out_clamp_reg <= clamp_reg;
            out_empty_reg <= empty_reg;
            unique case (pick_reg)
                kfli_pkg::PICK_END:
                begin
                    out_x_reg <= e_reg[0];
                    out_y_reg <= e_reg[1];
                    out_z_reg <= e_reg[2];
                end
                kfli_pkg::PICK_LERP:
                begin
                    out_x_reg <= r_reg[0];
                    out_y_reg <= r_reg[1];
                    out_z_reg <= r_reg[2];
                end
                default:
                begin
                    out_x_reg <= s_reg[0];
                    out_y_reg <= s_reg[1];
                    out_z_reg <= s_reg[2];
                end
            endcase
        end
    end

    assign out_x          = out_x_reg;
    assign out_y          = out_y_reg;
    assign out_z          = out_z_reg;
    assign segment        = out_seg_reg;
    assign factor_clamped = out_clamp_reg;
    assign empty_segment  = out_empty_reg;

endmodule

`default_nettype wire

[sv/kfli_ctrl.sv]
// sequencing state machine of the keyframe interpolator
`default_nettype none

module kfli_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              op,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire kfli_pkg::status_t status,
    output kfli_pkg::cmd_t         cmd
);

    localparam int CW = kfli_pkg::COMP_W;
    localparam int DW = kfli_pkg::DIV_CNT_W;

    kfli_pkg::state_t state_reg;
    kfli_pkg::state_t state_next;
    logic [DW-1:0]    div_cnt_reg;
    logic [DW-1:0]    div_cnt_next;
    logic [CW-1:0]    comp_reg;
    logic [CW-1:0]    comp_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kfli_pkg::ST_IDLE;
            div_cnt_reg   <= '0;
            comp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            comp_reg      <= comp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        comp_next    = comp_reg;
        cmd          = '0;
        cmd.comp     = comp_reg;
        in_ready     = 1'b0;

        unique case (state_reg)
            kfli_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (op == kfli_pkg::OP_LOAD)
                    begin
                        cmd.load_key = 1'b1;
                    end
                    else
                    begin
                        cmd.start_query = 1'b1;
                        state_next = status.single ? kfli_pkg::ST_FETCH_WAIT
                                                   : kfli_pkg::ST_SCAN_FILL;
                    end
                end
            end
            kfli_pkg::ST_SCAN_FILL:
            begin
                cmd.ptr_inc = 1'b1;
                state_next  = kfli_pkg::ST_SCAN;
            end
            kfli_pkg::ST_SCAN:
            begin
                if (status.hit || status.scan_last)
                begin
                    cmd.scan_done = 1'b1;
                    state_next    = kfli_pkg::ST_FETCH_WAIT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            kfli_pkg::ST_FETCH_WAIT:
            begin
                cmd.ptr_inc = 1'b1;
                state_next  = kfli_pkg::ST_FETCH_START;
            end
            kfli_pkg::ST_FETCH_START:
            begin
                cmd.latch_start = 1'b1;
                state_next = status.single ? kfli_pkg::ST_RESULT
                                           : kfli_pkg::ST_FETCH_END;
            end
            kfli_pkg::ST_FETCH_END:
            begin
                cmd.latch_end = 1'b1;
                state_next    = kfli_pkg::ST_CLASSIFY;
            end
            kfli_pkg::ST_CLASSIFY:
            begin
                cmd.classify = 1'b1;
                div_cnt_next = '0;
                state_next = status.need_div ? kfli_pkg::ST_DIVIDE
                                             : kfli_pkg::ST_RESULT;
            end
            kfli_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == DW'(kfli_pkg::DIV_STEPS - 1))
                begin
                    comp_next  = '0;
                    state_next = kfli_pkg::ST_DIFF;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + DW'(1);
                end
            end
            kfli_pkg::ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = kfli_pkg::ST_MUL;
            end
            kfli_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = kfli_pkg::ST_ACC;
            end
            kfli_pkg::ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (comp_reg == CW'(kfli_pkg::NUM_COMP - 1))
                begin
                    state_next = kfli_pkg::ST_RESULT;
                end
                else
                begin
                    comp_next  = comp_reg + CW'(1);
                    state_next = kfli_pkg::ST_DIFF;
                end
            end
            kfli_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = kfli_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kfli_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[sv/keyframe_linear_interpolator.sv]
// timing: a load finishes in its own cycle; a query with one key fetches that key and returns it,
// else it searches, fetches both keys and returns the start or end key, or runs the 16-step divider
// and interpolates; the key search is linear, one table read per cycle
// occupancy: one query at a time, no new item is taken until its result is written to the output register
// reset: rst_n asynchronous active low, clears control and sets key_count to 1;
// the key table is not cleared, entries must be loaded before they are queried
`default_nettype none

module keyframe_linear_interpolator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // key_count register write
    input  wire logic                              cfg_we,
    input  wire logic [kfli_pkg::KC_W-1:0]         cfg_data,
    // item channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              op,
    input  wire logic [kfli_pkg::IDX_W-1:0]        key_index,
    input  wire logic [kfli_pkg::TIME_W-1:0]       key_time,
    input  wire logic signed [kfli_pkg::VAL_W-1:0] key_x,
    input  wire logic signed [kfli_pkg::VAL_W-1:0] key_y,
    input  wire logic signed [kfli_pkg::VAL_W-1:0] key_z,
    input  wire logic [kfli_pkg::TIME_W-1:0]       query_time,
    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [kfli_pkg::VAL_W-1:0]      out_x,
    output logic signed [kfli_pkg::VAL_W-1:0]      out_y,
    output logic signed [kfli_pkg::VAL_W-1:0]      out_z,
    output logic [kfli_pkg::IDX_W-1:0]             segment,
    output logic                                   factor_clamped,
    output logic                                   empty_segment
);

    // command and status bundles between sequencer and datapath
    kfli_pkg::cmd_t    cmd;
    kfli_pkg::status_t status;

    // sequencer: search, fetch, divide and per-component lerp steps;
    // idle state takes a new transfer even while a result waits in the output register
    kfli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // key table memory, restoring divider, shared multiplier pair and output register
    kfli_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .key_index      (key_index),
        .key_time       (key_time),
        .key_x          (key_x),
        .key_y          (key_y),
        .key_z          (key_z),
        .query_time     (query_time),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_z          (out_z),
        .segment        (segment),
        .factor_clamped (factor_clamped),
        .empty_segment  (empty_segment)
    );

`ifndef SYNTHESIS
    // a load transfer finishes in its own cycle
    a_load_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == kfli_pkg::OP_LOAD) |=> in_ready)
        else $error("block busy after key load");

    // a query transfer occupies the block
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == kfli_pkg::OP_QUERY) |=> !in_ready)
        else $error("block idle right after query transfer");

    // a result is written only when the output register is free or drained
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("pending result overwritten");

    // chosen segment never starts at the last table slot
    a_segment_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (segment != kfli_pkg::IDX_W'(kfli_pkg::MAX_KEYS - 1)))
        else $error("segment index out of range");
`endif

endmodule

`default_nettype wire
